// File: rtl/cie94_pkg.sv
package cie94_pkg;

    localparam int CIE94_MAX_CENTROIDS = 64;

    // iterative square root: input width and root width
    localparam int SQRT_W = 54;
    localparam int ROOT_W = SQRT_W / 2;

    // iterative divider: numerator, divisor and quotient widths
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 26;

    localparam logic [16:0] DIST_MAX = 17'h1FFFF;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_MEASURE = 1'b1;

    localparam logic MODE_EUCLID = 1'b0;
    localparam logic MODE_CIE94  = 1'b1;

    localparam logic [1:0] REG_METRIC_MODE    = 2'd0;
    localparam logic [1:0] REG_CENTROID_COUNT = 2'd1;
    localparam logic [1:0] REG_K1_COEFF       = 2'd2;
    localparam logic [1:0] REG_K2_COEFF       = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [5:0]        slot;
        logic [14:0]       l_value;
        logic signed [15:0] a_value;
        logic signed [15:0] b_value;
    } cdm_in_t;

    typedef struct packed {
        logic [5:0]  centroid_index;
        logic [16:0] distance;
        logic        last;
    } cdm_out_t;

    // one centroid as held in a ring cell, with its chroma worked out at load
    typedef struct packed {
        logic [14:0]        l_value;
        logic signed [15:0] a_value;
        logic signed [15:0] b_value;
        logic [15:0]        chroma;
    } cen_entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_ROOT,
        ST_ROOTW,
        ST_SC,
        ST_SH,
        ST_SHW,
        ST_DIFF,
        ST_DL,
        ST_DA,
        ST_DB,
        ST_DC,
        ST_DH,
        ST_HQ,
        ST_TC,
        ST_TH,
        ST_SQTC,
        ST_SQTH,
        ST_SUM,
        ST_FIN,
        ST_PUT,
        ST_REWIND
    } cdm_state_t;

endpackage

// File: rtl/cie94_color_difference_matrix.sv
// load beat: the chroma of the new centroid is worked out through the square root unit
// measure beat: the colour chroma and weights first, then per centroid the euclidean or
// cie94 distance through the shared one-bit-per-cycle square root and divider, held by
// any output stall, then a rewind of the ring to home
// one beat in flight at a time; rst_n clears control and config, centroid ring is not cleared
module cie94_color_difference_matrix #(
    parameter int MAX_CENTROIDS = cie94_pkg::CIE94_MAX_CENTROIDS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cie94_pkg::cdm_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cie94_pkg::cdm_out_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import cie94_pkg::*;

    localparam int ROT_W = $clog2(MAX_CENTROIDS + 1);

    // configuration
    logic        mode_reg;
    logic [6:0]  count_reg;
    logic [15:0] k1_reg;
    logic [15:0] k2_reg;

    // control
    cdm_state_t  state_reg;
    cdm_state_t  state_next;
    logic [5:0]  j_reg;
    logic [6:0]  n_reg;
    logic [ROT_W-1:0] rot_reg;

    // beat held while it is worked on
    logic        type_reg;
    logic [5:0]  slot_reg;
    logic [14:0] l_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;

    // datapath registers
    logic [15:0] c1_reg;
    logic [31:0] sc_reg;
    logic [31:0] sh_reg;
    logic [15:0] dl_reg;
    logic [15:0] da_reg;
    logic [15:0] db_reg;
    logic [15:0] dc_reg;
    logic [53:0] acc_reg;
    logic [33:0] ab_reg;
    logic [51:0] mul_reg;
    logic [25:0] hq_reg;
    logic [23:0] tc_reg;
    logic [25:0] th_reg;

    // output stage
    logic        out_valid_reg;
    cdm_out_t    out_reg;

    // shared arithmetic
    logic [25:0] mul_a;
    logic [25:0] mul_b;
    logic        sq_start;
    logic [SQRT_W-1:0] sq_x;
    logic        sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic        dv_start;
    logic [DIV_NW-1:0] dv_num;
    logic [DIV_DW-1:0] dv_den;
    logic        dv_done;
    logic [DIV_QW-1:0] dv_quot;

    // ring of centroid cells, head is cell 0
    cen_entry_t  cells [MAX_CENTROIDS];
    cen_entry_t  head;
    cen_entry_t  wr_entry;
    logic        ring_shift;
    logic        load_commit;

    // combinational helpers
    logic signed [15:0] dl_s;
    logic signed [16:0] da_s;
    logic signed [16:0] db_s;
    logic signed [16:0] dc_s;
    logic signed [16:0] a_ext;
    logic signed [16:0] b_ext;
    logic [15:0] a_mag;
    logic [15:0] b_mag;
    logic [33:0] dh2;
    logic [18:0] root_hi;
    logic [16:0] dist_sat;
    logic        is_last;
    logic        out_free;

    assign head = cells[0];

    // ---------------------------------------------------------------- config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CIE94;
            count_reg <= 7'd1;
            k1_reg    <= 16'd2949;
            k2_reg    <= 16'd983;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_METRIC_MODE:    mode_reg  <= cfg_data[0];
                REG_CENTROID_COUNT: count_reg <= cfg_data[6:0];
                REG_K1_COEFF:       k1_reg    <= cfg_data;
                REG_K2_COEFF:       k2_reg    <= cfg_data;
                default:            mode_reg  <= mode_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- centroid ring
    // a load writes its slot while the ring sits at home; a measure rotates it
    // one place per centroid and rewinds it to home afterwards
    assign load_commit = (state_reg == ST_ROOTW) && sq_done && (type_reg == REQ_LOAD);
    assign wr_entry    = '{l_value: l_reg, a_value: a_reg, b_value: b_reg,
                           chroma: sq_root[15:0]};

    for (genvar i = 0; i < MAX_CENTROIDS; i++)
    begin : g_ring
        cie94_cell u_cell (
            .clk     (clk),
            .shift   (ring_shift),
            .wr_en   (load_commit && (slot_reg == 6'(i))),
            .wr_data (wr_entry),
            .nbr     (cells[(i + 1) % MAX_CENTROIDS]),
            .entry   (cells[i])
        );
    end

    // ---------------------------------------------------------------- arithmetic units
    cie94_isqrt #(
        .W (SQRT_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (sq_x),
        .done  (sq_done),
        .root  (sq_root)
    );

    cie94_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .QW (DIV_QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quot  (dv_quot)
    );

    // differences against the head centroid, as magnitudes
    assign dl_s  = $signed({1'b0, l_reg}) - $signed({1'b0, head.l_value});
    assign da_s  = $signed({a_reg[15], a_reg}) - $signed({head.a_value[15], head.a_value});
    assign db_s  = $signed({b_reg[15], b_reg}) - $signed({head.b_value[15], head.b_value});
    assign dc_s  = $signed({1'b0, c1_reg}) - $signed({1'b0, head.chroma});
    assign a_ext = {a_reg[15], a_reg};
    assign b_ext = {b_reg[15], b_reg};
    assign a_mag = a_ext[16] ? 16'(-a_ext) : 16'(a_ext);
    assign b_mag = b_ext[16] ? 16'(-b_ext) : 16'(b_ext);

    // dH squared, clamped at zero; mul_reg holds dC squared here
    assign dh2 = (ab_reg > 34'(mul_reg)) ? (ab_reg - 34'(mul_reg)) : '0;

    // operand select for the one shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQA:  begin mul_a = 26'(a_mag);  mul_b = 26'(a_mag);  end
            ST_SQB:  begin mul_a = 26'(b_mag);  mul_b = 26'(b_mag);  end
            ST_SC:   begin mul_a = 26'(k1_reg); mul_b = 26'(c1_reg); end
            ST_SH:   begin mul_a = 26'(k2_reg); mul_b = 26'(c1_reg); end
            ST_DL:   begin mul_a = 26'(dl_reg); mul_b = 26'(dl_reg); end
            ST_DA:   begin mul_a = 26'(da_reg); mul_b = 26'(da_reg); end
            ST_DB:   begin mul_a = 26'(db_reg); mul_b = 26'(db_reg); end
            ST_DC:   begin mul_a = 26'(dc_reg); mul_b = 26'(dc_reg); end
            ST_SQTC: begin mul_a = 26'(tc_reg); mul_b = 26'(tc_reg); end
            ST_SQTH: begin mul_a = th_reg;      mul_b = th_reg;      end
            default: begin mul_a = '0;          mul_b = '0;          end
        endcase
    end

    // square root launches: chroma, euclidean sum or dH, final cie94 sum
    always_comb
    begin
        sq_start = 1'b0;
        sq_x     = '0;
        unique case (state_reg)
            ST_ROOT:
            begin
                sq_start = 1'b1;
                sq_x     = acc_reg + SQRT_W'(mul_reg);
            end
            ST_DH:
            begin
                sq_start = 1'b1;
                if (mode_reg == MODE_EUCLID)
                begin
                    sq_x = acc_reg + SQRT_W'(ab_reg);
                end
                else
                begin
                    sq_x = SQRT_W'(dh2) << 16;
                end
            end
            ST_SUM:
            begin
                sq_start = 1'b1;
                sq_x     = acc_reg + SQRT_W'(mul_reg);
            end
            default:
            begin
                sq_start = 1'b0;
                sq_x     = '0;
            end
        endcase
    end

    // divider launches: |dC| / SC, then sqrt(dH) / SH
    always_comb
    begin
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = '0;
        if ((state_reg == ST_HQ) && sq_done)
        begin
            dv_start = 1'b1;
            dv_num   = {2'b00, dc_reg, 32'd0};
            dv_den   = sc_reg;
        end
        else if ((state_reg == ST_TC) && dv_done)
        begin
            dv_start = 1'b1;
            dv_num   = {hq_reg, 24'd0};
            dv_den   = sh_reg;
        end
    end

    // final distance, saturated
    assign root_hi = sq_root[ROOT_W-1:8];
    always_comb
    begin
        if (mode_reg == MODE_EUCLID)
        begin
            dist_sat = (sq_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : sq_root[16:0];
        end
        else
        begin
            dist_sat = (root_hi > 19'(DIST_MAX)) ? DIST_MAX : root_hi[16:0];
        end
    end

    assign is_last  = ({1'b0, j_reg} + 7'd1) == n_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign ring_shift = ((state_reg == ST_PUT) && out_free)
                     || ((state_reg == ST_REWIND) && (rot_reg != ROT_W'(MAX_CENTROIDS)));

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SQA;
            ST_SQA:    state_next = ST_SQB;
            ST_SQB:    state_next = ST_ROOT;
            ST_ROOT:   state_next = ST_ROOTW;
            ST_ROOTW:
            begin
                if (sq_done)
                begin
                    state_next = (type_reg == REQ_LOAD) ? ST_IDLE : ST_SC;
                end
            end
            ST_SC:     state_next = ST_SH;
            ST_SH:     state_next = ST_SHW;
            ST_SHW:    state_next = (count_reg == 7'd0) ? ST_IDLE : ST_DIFF;
            ST_DIFF:   state_next = ST_DL;
            ST_DL:     state_next = ST_DA;
            ST_DA:     state_next = ST_DB;
            ST_DB:     state_next = ST_DC;
            ST_DC:     state_next = ST_DH;
            ST_DH:     state_next = (mode_reg == MODE_EUCLID) ? ST_FIN : ST_HQ;
            ST_HQ:     if (sq_done) state_next = ST_TC;
            ST_TC:     if (dv_done) state_next = ST_TH;
            ST_TH:     if (dv_done) state_next = ST_SQTC;
            ST_SQTC:   state_next = ST_SQTH;
            ST_SQTH:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_FIN;
            ST_FIN:    if (sq_done) state_next = ST_PUT;
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_REWIND : ST_DIFF;
                end
            end
            ST_REWIND:
            begin
                if (rot_reg == ROT_W'(MAX_CENTROIDS))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg   <= '0;
            n_reg   <= '0;
            rot_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_SHW)
            begin
                j_reg   <= '0;
                rot_reg <= '0;
                n_reg   <= (count_reg > 7'(MAX_CENTROIDS)) ? 7'(MAX_CENTROIDS) : count_reg;
            end
            else
            begin
                if (ring_shift)
                begin
                    rot_reg <= rot_reg + 1'b1;
                end
                if ((state_reg == ST_PUT) && out_free && !is_last)
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    type_reg <= in_data.req_type;
                    slot_reg <= in_data.slot;
                    l_reg    <= in_data.l_value;
                    a_reg    <= in_data.a_value;
                    b_reg    <= in_data.b_value;
                end
            end
            ST_SQB:   acc_reg <= 54'(mul_reg);
            ST_ROOTW: if (sq_done) c1_reg <= sq_root[15:0];
            ST_SH:    sc_reg <= 32'h0100_0000 + 32'(mul_reg);
            ST_SHW:   sh_reg <= 32'h0100_0000 + 32'(mul_reg);
            ST_DIFF:
            begin
                dl_reg <= dl_s[15] ? 16'(-dl_s) : 16'(dl_s);
                da_reg <= da_s[16] ? 16'(-da_s) : 16'(da_s);
                db_reg <= db_s[16] ? 16'(-db_s) : 16'(db_s);
                dc_reg <= dc_s[16] ? 16'(-dc_s) : 16'(dc_s);
            end
            ST_DA:    acc_reg <= 54'(mul_reg);
            ST_DB:    ab_reg  <= 34'(mul_reg);
            ST_DC:    ab_reg  <= ab_reg + 34'(mul_reg);
            ST_DH:    acc_reg <= acc_reg << 16;
            ST_HQ:    if (sq_done) hq_reg <= sq_root[25:0];
            ST_TC:    if (dv_done) tc_reg <= dv_quot[23:0];
            ST_TH:    if (dv_done) th_reg <= dv_quot;
            ST_SQTH:  acc_reg <= acc_reg + 54'(mul_reg);
            default:  acc_reg <= acc_reg;
        endcase
    end

    // ---------------------------------------------------------------- output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_PUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_PUT) && out_free)
        begin
            out_reg <= '{centroid_index: j_reg, distance: dist_sat, last: is_last};
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/cie94_cell.sv
module cie94_cell (
    input  logic                  clk,
    input  logic                  shift,
    input  logic                  wr_en,
    input  cie94_pkg::cen_entry_t wr_data,
    input  cie94_pkg::cen_entry_t nbr,
    output cie94_pkg::cen_entry_t entry
);
    import cie94_pkg::*;

    cen_entry_t entry_reg;

    // load from the write port, else take the neighbour's entry on a shift
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
        else if (shift)
        begin
            entry_reg <= nbr;
        end
    end

    assign entry = entry_reg;

endmodule

// File: rtl/cie94_isqrt.sv
module cie94_isqrt #(
    parameter int W = cie94_pkg::SQRT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     x,
    output logic             done,
    output logic [W/2-1:0]   root
);
    import cie94_pkg::*;

    localparam int RW = W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [W-1:0]  x_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          take;

    // one root bit per cycle, two radicand bits brought down
    assign rem_sh = {rem_reg, x_reg[W-1:W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= (RW+1)'(rem_sh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/cie94_div.sv
module cie94_div #(
    parameter int NW = cie94_pkg::DIV_NW,
    parameter int DW = cie94_pkg::DIV_DW,
    parameter int QW = cie94_pkg::DIV_QW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);
    import cie94_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] lo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   rem_sh;
    logic          take;

    // restoring division, quotient known to fit QW bits so the top part starts below den
    assign rem_sh = {rem_reg, lo_reg[QW-1]};
    assign take   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num[NW-1:QW]);
            lo_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= DW'(rem_sh - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
            end
            lo_reg <= {lo_reg[QW-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule
